@@ hdl/lbpc_pkg.sv @@
// Shared constants, types and helper functions for the letterbox pad/crop mapper.
`timescale 1ns / 1ps

package lbpc_pkg;

    // Largest source or canvas dimension; larger sizes saturate to it.
    localparam int MAX_DIM = 4096;
    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = POS_W + 1;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_ALIGN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VERT_ALIGN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT  = 3'd4;

    // Alignment codes; the unused code behaves as center.
    localparam logic [1:0] ALIGN_LEAD   = 2'd0;
    localparam logic [1:0] ALIGN_CENTER = 2'd1;
    localparam logic [1:0] ALIGN_TRAIL  = 2'd2;

    // Pixel format codes selecting the black pattern.
    localparam logic [1:0] FMT_ZERO   = 2'd0;
    localparam logic [1:0] FMT_YUV444 = 2'd1;
    localparam logic [1:0] FMT_YUYV   = 2'd2;
    localparam logic [1:0] FMT_UYVY   = 2'd3;

    localparam logic [31:0] BLACK_ZERO   = 32'h0000_0000;
    localparam logic [31:0] BLACK_YUV444 = 32'h0080_8000;
    localparam logic [31:0] BLACK_YUYV   = 32'h0000_8000;
    localparam logic [31:0] BLACK_UYVY   = 32'h0000_0080;

    localparam logic [12:0] RST_CANVAS_WIDTH  = 13'd800;
    localparam logic [12:0] RST_CANVAS_HEIGHT = 13'd600;

    // Result of mapping one axis.
    typedef struct packed {
        logic             blank;
        logic [POS_W-1:0] coord;
    } t_axis_res;

    // Saturate a dimension to the largest supported size.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [12:0] v);
        logic [DIM_W-1:0] r;
        r = (DIM_W'(v) > DIM_MAX) ? DIM_MAX : DIM_W'(v);
        return r;
    endfunction

    // Offset on the leading side when big exceeds small.
    function automatic logic [DIM_W-1:0] lead_offset(input logic [DIM_W-1:0] small_sz,
                                                     input logic [DIM_W-1:0] big_sz,
                                                     input logic [1:0]       align);
        logic [DIM_W-1:0] diff;
        logic [DIM_W-1:0] r;
        diff = big_sz - small_sz;
        if (big_sz <= small_sz || align == ALIGN_LEAD) begin
            r = '0;
        end else if (align == ALIGN_TRAIL) begin
            r = diff;
        end else begin
            r = diff >> 1;
        end
        return r;
    endfunction

    // Black pixel bytes for a pixel format, first byte in the low bits.
    function automatic logic [31:0] black_pattern(input logic [1:0] fmt);
        logic [31:0] r;
        unique case (fmt)
            FMT_YUV444: r = BLACK_YUV444;
            FMT_YUYV:   r = BLACK_YUYV;
            FMT_UYVY:   r = BLACK_UYVY;
            default:    r = BLACK_ZERO;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/lbpc_axis_map.sv @@
// Maps one canvas coordinate to a source coordinate or blank along one axis.
`timescale 1ns / 1ps

module lbpc_axis_map (
    input  logic [lbpc_pkg::POS_W-1:0] i_pos,
    input  logic [12:0]                i_src,
    input  logic [12:0]                i_canvas,
    input  logic [1:0]                 i_align,
    output lbpc_pkg::t_axis_res        o_res
);

    logic [lbpc_pkg::DIM_W-1:0] src_c;
    logic [lbpc_pkg::DIM_W-1:0] canvas_c;
    logic [lbpc_pkg::DIM_W-1:0] pad;
    logic [lbpc_pkg::DIM_W-1:0] crop;
    logic [lbpc_pkg::DIM_W-1:0] active;
    logic [lbpc_pkg::DIM_W-1:0] pos_ext;
    logic [lbpc_pkg::DIM_W-1:0] rel;
    logic [lbpc_pkg::DIM_W-1:0] mapped;
    logic                       blank;

    assign src_c    = lbpc_pkg::clamp_dim(i_src);
    assign canvas_c = lbpc_pkg::clamp_dim(i_canvas);
    assign pad      = lbpc_pkg::lead_offset(src_c, canvas_c, i_align);
    assign crop     = lbpc_pkg::lead_offset(canvas_c, src_c, i_align);
    assign active   = (src_c < canvas_c) ? src_c : canvas_c;
    assign pos_ext  = {1'b0, i_pos};
    assign rel      = pos_ext - pad;
    assign mapped   = rel + crop;

    // Blank outside the canvas, in the leading pad, or past the active span.
    assign blank = (pos_ext >= canvas_c) || (pos_ext < pad) || (rel >= active);

    assign o_res.blank = blank;
    assign o_res.coord = blank ? '0 : mapped[lbpc_pkg::POS_W-1:0];

endmodule

@@ hdl/letterbox_pad_crop_mapper.sv @@
// Top level of the letterbox pad/crop mapper: config registers and two-stage pipeline.
`timescale 1ns / 1ps
// The input item is registered in the input stage, then in the result stage, which drives the result channel.
// Throughput: one item per clock while the result is taken; the per-axis map is a few adds and compares in one stage.
// Input ready drops only when both stages hold items and the result is not taken.
// Reset (i_rst_n low, synchronous) empties both stages and loads canvas 800x600,
// center alignment on both axes and the all-zero black pattern.

module letterbox_pad_crop_mapper (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // Configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lbpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [12:0]                    i_cfg_data,

    // Input item channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [12:0]                    i_src_width,
    input  logic [12:0]                    i_src_height,
    input  logic [lbpc_pkg::POS_W-1:0]     i_canvas_x,
    input  logic [lbpc_pkg::POS_W-1:0]     i_canvas_y,

    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_is_blank,
    output logic [lbpc_pkg::POS_W-1:0]     o_source_x,
    output logic [lbpc_pkg::POS_W-1:0]     o_source_y,
    output logic [31:0]                    o_black_pixel
);

    // Configuration registers
    logic [12:0] r_canvas_width;
    logic [12:0] r_canvas_height;
    logic [1:0]  r_horiz_align;
    logic [1:0]  r_vert_align;
    logic [1:0]  r_pixel_format;

    // Input stage
    logic                       r_s1_valid;
    logic                       n_s1_valid;
    logic [12:0]                r_s1_src_width;
    logic [12:0]                r_s1_src_height;
    logic [lbpc_pkg::POS_W-1:0] r_s1_canvas_x;
    logic [lbpc_pkg::POS_W-1:0] r_s1_canvas_y;

    // Result stage
    logic                       r_s2_valid;
    logic                       n_s2_valid;
    logic                       r_s2_blank;
    logic [lbpc_pkg::POS_W-1:0] r_s2_source_x;
    logic [lbpc_pkg::POS_W-1:0] r_s2_source_y;
    logic [31:0]                r_s2_black;

    logic s2_ready;
    logic s1_ready;
    logic in_xfer;
    logic s1_advance;

    lbpc_pkg::t_axis_res res_x;
    lbpc_pkg::t_axis_res res_y;

    // Configuration is always accepted; the user must write only while the pipe is empty (not enforced).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width  <= lbpc_pkg::RST_CANVAS_WIDTH;
            r_canvas_height <= lbpc_pkg::RST_CANVAS_HEIGHT;
            r_horiz_align   <= lbpc_pkg::ALIGN_CENTER;
            r_vert_align    <= lbpc_pkg::ALIGN_CENTER;
            r_pixel_format  <= lbpc_pkg::FMT_ZERO;
        end else if (i_cfg_valid && o_cfg_ready) begin
            // Drop writes to indexes past the register list.
            unique case (i_cfg_index)
                lbpc_pkg::CFG_CANVAS_WIDTH:  r_canvas_width  <= i_cfg_data;
                lbpc_pkg::CFG_CANVAS_HEIGHT: r_canvas_height <= i_cfg_data;
                lbpc_pkg::CFG_HORIZ_ALIGN:   r_horiz_align   <= i_cfg_data[1:0];
                lbpc_pkg::CFG_VERT_ALIGN:    r_vert_align    <= i_cfg_data[1:0];
                lbpc_pkg::CFG_PIXEL_FORMAT:  r_pixel_format  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow: a stage takes a new item when empty or when its content moves on.
    assign s2_ready   = !r_s2_valid || i_out_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_ready = s1_ready;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign s1_advance = r_s1_valid && s2_ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (s1_ready) begin
            n_s1_valid = i_in_valid;
        end
        n_s2_valid = r_s2_valid;
        if (s2_ready) begin
            n_s2_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    // Capture the input item on its transfer.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_src_width  <= i_src_width;
            r_s1_src_height <= i_src_height;
            r_s1_canvas_x   <= i_canvas_x;
            r_s1_canvas_y   <= i_canvas_y;
        end
    end

    // Map each axis from the held input item.
    lbpc_axis_map u_map_x (
        .i_pos    (r_s1_canvas_x),
        .i_src    (r_s1_src_width),
        .i_canvas (r_canvas_width),
        .i_align  (r_horiz_align),
        .o_res    (res_x)
    );

    lbpc_axis_map u_map_y (
        .i_pos    (r_s1_canvas_y),
        .i_src    (r_s1_src_height),
        .i_canvas (r_canvas_height),
        .i_align  (r_vert_align),
        .o_res    (res_y)
    );

    // Advance into the result register; a blank on either axis zeroes both coordinates.
    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_s2_blank    <= res_x.blank || res_y.blank;
            r_s2_source_x <= (res_x.blank || res_y.blank) ? '0 : res_x.coord;
            r_s2_source_y <= (res_x.blank || res_y.blank) ? '0 : res_y.coord;
            r_s2_black    <= lbpc_pkg::black_pattern(r_pixel_format);
        end
    end

    assign o_out_valid   = r_s2_valid;
    assign o_is_blank    = r_s2_blank;
    assign o_source_x    = r_s2_source_x;
    assign o_source_y    = r_s2_source_y;
    assign o_black_pixel = r_s2_black;

endmodule
